FILE: design/i2c_master_transaction_sequencer_unit_macros.svh
// Assertion macros used by the sequencer core.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define I2CMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define I2CMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/i2cms_pkg.sv
// Types, codes and sizes shared by the I2C transaction sequencer.
package i2cms_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int POS_W     = $clog2(BUF_DEPTH);
    localparam int COUNT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BUF_DEPTH);

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_PROBE    = 3'd2;
    localparam logic [2:0] OP_NACK     = 3'd3;
    localparam logic [2:0] OP_RX_EVENT = 3'd4;
    localparam logic [2:0] OP_TX_READY = 3'd5;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NACK   = 3'd1;
    localparam logic [2:0] MODE_TXREG  = 3'd2;
    localparam logic [2:0] MODE_TORX   = 3'd3;
    localparam logic [2:0] MODE_RXDATA = 3'd4;
    localparam logic [2:0] MODE_TXDATA = 3'd5;
    localparam logic [2:0] MODE_PROBE  = 3'd6;
    localparam logic [2:0] MODE_ACK    = 3'd7;

    localparam logic [7:0] PROBE_BYTE = 8'h00;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         register_address;
        logic [COUNT_W-1:0] receive_count;
        logic [COUNT_W-1:0] transmit_count;
        logic [3:0]         load_index;
        logic [7:0]         data_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       send_start;
        logic       send_stop;
        logic       to_receiver;
        logic       rx_valid;
        logic [3:0] rx_slot;
        logic [7:0] rx_byte;
        logic       listen_rx;
        logic       listen_tx;
        logic [2:0] mode;
    } result_t;

endpackage

FILE: design/i2cms_core.sv
// Sequencer state, transmit store and per-request next-state logic.
`include "i2c_master_transaction_sequencer_unit_macros.svh"

module i2cms_core
    import i2cms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    commit,
    output result_t result
);

    logic [2:0]         mode_reg,         mode_next;
    logic [COUNT_W-1:0] rx_remaining_reg, rx_remaining_next;
    logic [COUNT_W-1:0] tx_remaining_reg, tx_remaining_next;
    logic [POS_W-1:0]   tx_position_reg,  tx_position_next;
    logic [POS_W-1:0]   rx_position_reg,  rx_position_next;
    logic [7:0]         reg_address_reg,  reg_address_next;
    logic               rx_enable_reg,    rx_enable_next;
    logic               tx_enable_reg,    tx_enable_next;

    logic [7:0] tx_store_reg [BUF_DEPTH];
    logic       store_write;

    logic [COUNT_W-1:0] rx_left;

    always_comb
    begin
        mode_next         = mode_reg;
        rx_remaining_next = rx_remaining_reg;
        tx_remaining_next = tx_remaining_reg;
        tx_position_next  = tx_position_reg;
        rx_position_next  = rx_position_reg;
        reg_address_next  = reg_address_reg;
        rx_enable_next    = rx_enable_reg;
        tx_enable_next    = tx_enable_reg;
        store_write       = 1'b0;
        rx_left           = rx_remaining_reg;
        result            = '0;

        case (item.operation)
            OP_START:
            begin
                reg_address_next  = item.register_address;
                rx_remaining_next = (item.receive_count > COUNT_MAX) ? COUNT_MAX
                                                                     : item.receive_count;
                tx_remaining_next = (item.transmit_count > COUNT_MAX) ? COUNT_MAX
                                                                      : item.transmit_count;
                tx_position_next  = '0;
                rx_position_next  = '0;
                mode_next         = MODE_TXREG;
                tx_enable_next    = 1'b1;
                rx_enable_next    = 1'b0;
                result.send_start = 1'b1;
            end
            OP_LOAD:
            begin
                store_write = 1'b1;
            end
            OP_PROBE:
            begin
                mode_next         = MODE_PROBE;
                tx_enable_next    = 1'b1;
                rx_enable_next    = 1'b0;
                result.send_start = 1'b1;
            end
            OP_NACK:
            begin
                mode_next        = MODE_NACK;
                result.send_stop = 1'b1;
            end
            OP_RX_EVENT:
            begin
                if (rx_enable_reg)
                begin
                    if (rx_remaining_reg != '0)
                    begin
                        result.rx_valid  = 1'b1;
                        result.rx_slot   = 4'(rx_position_reg);
                        result.rx_byte   = item.data_byte;
                        rx_position_next = rx_position_reg + 1'b1;
                        rx_left          = rx_remaining_reg - 1'b1;
                    end
                    rx_remaining_next = rx_left;
                    // stop goes out ahead of the final byte
                    if (rx_left == COUNT_W'(1))
                    begin
                        result.send_stop = 1'b1;
                    end
                    else if (rx_left == '0)
                    begin
                        rx_enable_next = 1'b0;
                        mode_next      = MODE_IDLE;
                    end
                end
            end
            OP_TX_READY:
            begin
                if (tx_enable_reg)
                begin
                    case (mode_reg)
                        MODE_TXREG:
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = reg_address_reg;
                            mode_next = (rx_remaining_reg != '0) ? MODE_TORX : MODE_TXDATA;
                        end
                        MODE_TORX:
                        begin
                            rx_enable_next     = 1'b1;
                            tx_enable_next     = 1'b0;
                            result.to_receiver = 1'b1;
                            result.send_start  = 1'b1;
                            mode_next          = MODE_RXDATA;
                            result.send_stop   = (rx_remaining_reg == COUNT_W'(1));
                        end
                        MODE_TXDATA:
                        begin
                            if (tx_remaining_reg != '0)
                            begin
                                result.tx_valid   = 1'b1;
                                result.tx_byte    = tx_store_reg[tx_position_reg];
                                tx_position_next  = tx_position_reg + 1'b1;
                                tx_remaining_next = tx_remaining_reg - 1'b1;
                            end
                            else
                            begin
                                result.send_stop = 1'b1;
                                mode_next        = MODE_IDLE;
                                tx_enable_next   = 1'b0;
                            end
                        end
                        MODE_PROBE:
                        begin
                            mode_next        = MODE_ACK;
                            tx_enable_next   = 1'b0;
                            result.send_stop = 1'b1;
                            result.tx_valid  = 1'b1;
                            result.tx_byte   = PROBE_BYTE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        result.listen_rx = rx_enable_next;
        result.listen_tx = tx_enable_next;
        result.mode      = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            rx_remaining_reg <= '0;
            tx_remaining_reg <= '0;
            tx_position_reg  <= '0;
            rx_position_reg  <= '0;
            reg_address_reg  <= '0;
            rx_enable_reg    <= 1'b0;
            tx_enable_reg    <= 1'b0;
        end
        else if (commit)
        begin
            mode_reg         <= mode_next;
            rx_remaining_reg <= rx_remaining_next;
            tx_remaining_reg <= tx_remaining_next;
            tx_position_reg  <= tx_position_next;
            rx_position_reg  <= rx_position_next;
            reg_address_reg  <= reg_address_next;
            rx_enable_reg    <= rx_enable_next;
            tx_enable_reg    <= tx_enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && store_write)
        begin
            tx_store_reg[item.load_index[POS_W-1:0]] <= item.data_byte;
        end
    end

    `I2CMS_ASSERT(a_enables_exclusive, !(rx_enable_reg && tx_enable_reg), "both event enables set")
    `I2CMS_ASSERT_IMPL(a_rxdata_listens, mode_reg == MODE_RXDATA, rx_enable_reg, "rx data mode without rx enable")
    `I2CMS_ASSERT_IMPL(a_txreg_listens, mode_reg == MODE_TXREG, tx_enable_reg, "tx regaddr mode without tx enable")
    `I2CMS_ASSERT(a_counts_clamped, (rx_remaining_reg <= COUNT_MAX) && (tx_remaining_reg <= COUNT_MAX), "count above buffer depth")

endmodule

FILE: design/i2c_master_transaction_sequencer_unit.sv
// I2C master register transaction sequencer: request and result registers around the core.
//
// Usage: each request on the s_ side is one command (start, load tx byte, probe) or one
// bus event (nack, byte received, transmitter ready). Exactly one result comes out on
// the m_ side for every request, in order, carrying the bus actions to take and the
// event enables and mode after that request.
// Path: a request accepted into the request register has its result computed by the core,
// captured in the result register and shown on m_tvalid as soon as that register is free
// to take it.
// Throughput: one request per cycle while m_tready does not stall the result; the state update
// is a single pass through the core logic between the request register and the result register.
// Reset: rst_n clears the valid flags of both register stages and the sequencer to idle with counts,
// positions and enables at zero; the transmit store holds no defined data until loaded.
// Stall: while m_tready is low the result holds; one more request is taken into the
// request register and waits there, then s_tready drops until the result moves.
module i2c_master_transaction_sequencer_unit
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // register_address, receive_count, transmit_count,
                                  // load_index, data_byte, zero pad
    input  logic [2:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // tx_valid, tx_byte, send_start, send_stop, to_receiver,
                                  // rx_valid, rx_slot, rx_byte, listen_rx, listen_tx,
                                  // mode, zero pad
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    item_t   s_item;
    logic    advance;

    always_comb
    begin
        s_item.operation        = s_tuser;
        s_item.register_address = s_tdata[7:0];
        s_item.receive_count    = s_tdata[12:8];
        s_item.transmit_count   = s_tdata[17:13];
        s_item.load_index       = s_tdata[21:18];
        s_item.data_byte        = s_tdata[29:22];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    i2cms_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item_reg),
        .commit (advance),
        .result (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_result_reg.mode,
                       out_result_reg.listen_tx,
                       out_result_reg.listen_rx,
                       out_result_reg.rx_byte,
                       out_result_reg.rx_slot,
                       out_result_reg.rx_valid,
                       out_result_reg.to_receiver,
                       out_result_reg.send_stop,
                       out_result_reg.send_start,
                       out_result_reg.tx_byte,
                       out_result_reg.tx_valid};

endmodule
